### src/pfla_pkg.sv
`default_nettype none

package pfla_pkg;

  // fixed field widths
  localparam int unsigned PAGE_W   = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID      = 2'd3;

  // input commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register byte address
  localparam logic [1:0] REG_ADDR_PAGES_IN_USE = 2'd0;

  typedef struct packed {
    logic               cmd;
    logic [COUNT_W-1:0] alloc_count;
    logic [PAGE_W-1:0]  page_id;
    logic               batch_last;
  } pfla_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_out;
    logic                page_valid;
    logic                last_result;
    logic [COUNT_W-1:0]  free_pages_left;
  } pfla_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN_RD,
    ST_SCAN,
    ST_PUSH_RD,
    ST_PUSH,
    ST_RESULT
  } pfla_state_e;

  // controller to datapath
  typedef struct packed {
    logic                pop_rd;
    logic                pop_emit;
    logic                cnt_load;
    logic                buf_wr;
    logic                ptr_clr;
    logic                buf_rd;
    logic                push;
    logic                stat_load;
    logic [STATUS_W-1:0] stat_val;
    logic                res_emit;
    logic                batch_clr;
  } pfla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic is_last;
    logic alloc_zero;
    logic alloc_too_big;
    logic batch_err_now;
    logic rem_last;
    logic ptr_more;
    logic id_bad;
    logic id_free;
    logic batch_too_big;
    logic out_free;
  } pfla_sts_t;

endpackage

`default_nettype wire

### src/pfla_ctrl.sv
`default_nettype none

module pfla_ctrl import pfla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pfla_sts_t sts_i,
  output pfla_cmd_t cmd_o
);

  pfla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_alloc) begin
            if (sts_i.alloc_too_big) begin
              state_d = ST_RESULT;
            end else if (!sts_i.alloc_zero) begin
              state_d = ST_POP;
            end
          end else if (sts_i.is_last) begin
            state_d = sts_i.batch_err_now ? ST_RESULT : ST_SCAN_RD;
          end
        end
      end
      ST_POP: begin
        if (sts_i.out_free && sts_i.rem_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.id_bad || sts_i.id_free) begin
          state_d = ST_RESULT;
        end else if (!sts_i.ptr_more) begin
          state_d = sts_i.batch_too_big ? ST_RESULT : ST_PUSH_RD;
        end
      end
      ST_PUSH_RD: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!sts_i.ptr_more) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_alloc) begin
            if (sts_i.alloc_too_big) begin
              cmd_o.stat_load = 1'b1;
              cmd_o.stat_val  = STATUS_NO_SPACE;
            end else if (!sts_i.alloc_zero) begin
              cmd_o.cnt_load = 1'b1;
              cmd_o.pop_rd   = 1'b1;
            end
          end else begin
            cmd_o.buf_wr = 1'b1;
            if (sts_i.is_last) begin
              if (sts_i.batch_err_now) begin
                cmd_o.stat_load = 1'b1;
                cmd_o.stat_val  = STATUS_BAD_ID;
                cmd_o.batch_clr = 1'b1;
              end else begin
                cmd_o.ptr_clr = 1'b1;
              end
            end
          end
        end
      end
      ST_POP: begin
        if (sts_i.out_free) begin
          cmd_o.pop_emit = 1'b1;
          cmd_o.pop_rd   = !sts_i.rem_last;
        end
      end
      ST_SCAN_RD: cmd_o.buf_rd = 1'b1;
      ST_SCAN: begin
        if (sts_i.id_bad) begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_val  = STATUS_BAD_ID;
          cmd_o.batch_clr = 1'b1;
        end else if (sts_i.id_free) begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_val  = STATUS_DOUBLE_FREE;
          cmd_o.batch_clr = 1'b1;
        end else if (sts_i.ptr_more) begin
          cmd_o.buf_rd = 1'b1;
        end else if (sts_i.batch_too_big) begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_val  = STATUS_BAD_ID;
          cmd_o.batch_clr = 1'b1;
        end else begin
          cmd_o.ptr_clr = 1'b1;
        end
      end
      ST_PUSH_RD: cmd_o.buf_rd = 1'b1;
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (sts_i.ptr_more) begin
          cmd_o.buf_rd = 1'b1;
        end else begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_val  = STATUS_OK;
          cmd_o.batch_clr = 1'b1;
        end
      end
      ST_RESULT: begin
        cmd_o.res_emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/pfla_dpath.sv
`default_nettype none

module pfla_dpath import pfla_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfla_cmd_t          cmd_i,
  output pfla_sts_t          sts_o,
  input  pfla_req_t          in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output pfla_rsp_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  output logic [COUNT_W-1:0] pages_in_use_o
);

  localparam int unsigned IdxW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CntW = $clog2(POOL_PAGES + 1);

  // stack and batch buffer storage
  logic [PAGE_W-1:0] stack_mem [POOL_PAGES];
  logic [PAGE_W-1:0] buf_mem   [POOL_PAGES];

  logic [CntW-1:0]       pages_in_use_q;
  logic [CntW-1:0]       depth_q;
  logic [CntW-1:0]       fill_q;
  logic [CntW-1:0]       ptr_q;
  logic [CntW-1:0]       rem_q;
  logic                  batch_err_q;
  logic [POOL_PAGES-1:0] slot_vld_q;
  logic [POOL_PAGES-1:0] page_free_q;
  logic                  out_valid_q;
  pfla_rsp_t             out_q;
  logic [STATUS_W-1:0]   stat_q;

  logic [PAGE_W-1:0] stk_rd_q;
  logic [PAGE_W-1:0] stk_init_q;
  logic              stk_vld_rd_q;
  logic [PAGE_W-1:0] buf_rd_q;

  logic [CntW-1:0]       cfg_pages;
  logic [POOL_PAGES-1:0] free_init;
  logic [IdxW-1:0]       st_rd_idx;
  logic [IdxW-1:0]       st_wr_idx;
  logic [PAGE_W-1:0]     pop_page;
  logic                  buf_has_room;
  logic                  out_free;

  // saturate the written page count
  assign cfg_pages = (cfg_wdata_i > COUNT_W'(POOL_PAGES)) ? CntW'(POOL_PAGES)
                                                          : CntW'(cfg_wdata_i);

  always_comb begin
    for (int i = 0; i < POOL_PAGES; i++) begin
      free_init[i] = (i < int'(cfg_pages));
    end
  end

  assign st_rd_idx    = IdxW'(depth_q - CntW'(1));
  assign st_wr_idx    = IdxW'(depth_q);
  assign pop_page     = stk_vld_rd_q ? stk_rd_q : stk_init_q;
  assign buf_has_room = (fill_q < CntW'(POOL_PAGES));
  assign out_free     = !out_valid_q || out_ready_i;

  // stack memory, unwritten slots fall back to the reset pattern
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[st_wr_idx] <= buf_rd_q;
    end
    if (cmd_i.pop_rd) begin
      stk_rd_q     <= stack_mem[st_rd_idx];
      stk_vld_rd_q <= slot_vld_q[st_rd_idx];
      stk_init_q   <= PAGE_W'(pages_in_use_q - CntW'(st_rd_idx) - CntW'(1));
    end
  end

  // batch buffer memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr && buf_has_room) begin
      buf_mem[IdxW'(fill_q)] <= in_data_i.page_id;
    end
    if (cmd_i.buf_rd) begin
      buf_rd_q <= buf_mem[IdxW'(ptr_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_in_use_q <= CntW'(POOL_PAGES);
      depth_q        <= CntW'(POOL_PAGES);
      fill_q         <= '0;
      ptr_q          <= '0;
      rem_q          <= '0;
      batch_err_q    <= 1'b0;
      slot_vld_q     <= '0;
      page_free_q    <= '1;
      out_valid_q    <= 1'b0;
    end else if (cfg_we_i) begin
      pages_in_use_q <= cfg_pages;
      depth_q        <= cfg_pages;
      fill_q         <= '0;
      batch_err_q    <= 1'b0;
      slot_vld_q     <= '0;
      page_free_q    <= free_init;
    end else begin
      if (cmd_i.pop_rd) begin
        depth_q <= depth_q - CntW'(1);
      end else if (cmd_i.push) begin
        depth_q <= depth_q + CntW'(1);
      end

      if (cmd_i.cnt_load) begin
        rem_q <= CntW'(in_data_i.alloc_count);
      end else if (cmd_i.pop_emit) begin
        rem_q <= rem_q - CntW'(1);
      end

      if (cmd_i.batch_clr) begin
        fill_q      <= '0;
        batch_err_q <= 1'b0;
      end else if (cmd_i.buf_wr) begin
        if (buf_has_room) begin
          fill_q <= fill_q + CntW'(1);
        end else begin
          batch_err_q <= 1'b1;
        end
      end

      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.buf_rd) begin
        ptr_q <= ptr_q + CntW'(1);
      end

      if (cmd_i.push) begin
        slot_vld_q[st_wr_idx]            <= 1'b1;
        page_free_q[buf_rd_q[IdxW-1:0]] <= 1'b1;
      end
      if (cmd_i.pop_emit) begin
        page_free_q[pop_page[IdxW-1:0]] <= 1'b0;
      end

      if (cmd_i.pop_emit || cmd_i.res_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload and pending status
  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_load) begin
      stat_q <= cmd_i.stat_val;
    end
    if (cmd_i.pop_emit) begin
      out_q.status          <= STATUS_OK;
      out_q.page_out        <= pop_page;
      out_q.page_valid      <= 1'b1;
      out_q.last_result     <= (rem_q == CntW'(1));
      out_q.free_pages_left <= COUNT_W'(depth_q);
    end else if (cmd_i.res_emit) begin
      out_q.status          <= stat_q;
      out_q.page_out        <= '0;
      out_q.page_valid      <= 1'b0;
      out_q.last_result     <= 1'b1;
      out_q.free_pages_left <= COUNT_W'(depth_q);
    end
  end

  always_comb begin
    sts_o.is_alloc      = (in_data_i.cmd == CMD_ALLOC);
    sts_o.is_last       = in_data_i.batch_last;
    sts_o.alloc_zero    = (in_data_i.alloc_count == '0);
    sts_o.alloc_too_big = (in_data_i.alloc_count > COUNT_W'(depth_q));
    sts_o.batch_err_now = batch_err_q || !buf_has_room;
    sts_o.rem_last      = (rem_q == CntW'(1));
    sts_o.ptr_more      = (ptr_q < fill_q);
    sts_o.id_bad        = (COUNT_W'(buf_rd_q) >= COUNT_W'(pages_in_use_q));
    sts_o.id_free       = (COUNT_W'(buf_rd_q) < COUNT_W'(POOL_PAGES))
                          && page_free_q[buf_rd_q[IdxW-1:0]];
    sts_o.batch_too_big = ((CntW+1)'(depth_q) + (CntW+1)'(fill_q))
                          > (CntW+1)'(POOL_PAGES);
    sts_o.out_free      = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign pages_in_use_o = COUNT_W'(pages_in_use_q);

endmodule

`default_nettype wire

### src/page_free_list_allocator_core.sv
// free page allocator: a lifo stack of free page numbers with a free bitmap
// input channel (valid/ready) takes one transaction per command: an allocate
// of alloc_count pages, or one page id of a free batch marked by batch_last
// output channel (valid/ready) returns results through one output register
// allocate of n pages: n results, one per cycle while the receiver keeps up;
// the next command is taken the cycle after the last result is loaded; a
// request larger than the free count gives one error result with status
// no_space; a count of zero gives no result and the block is ready again
// a free id that is not last is buffered with no result
// the last id of a batch starts a commit: the buffer is scanned one id per
// cycle against range and the free bitmap, the stack is checked for room,
// then the ids are pushed one id per cycle; a batch has a single result, and
// the next command can be taken in the same cycle that the result is valid
// the stack, buffer and bitmap each move one entry per cycle; one command
// is in flight at a time
// when the receiver stalls the result is held and the controller waits
// reset (or a write of pages_in_use) restores the full pool with page 0 on
// top and drops any partial batch; no clearing pass is needed
`default_nettype none

module page_free_list_allocator_core import pfla_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pfla_req_t   in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pfla_rsp_t   out_data_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pfla_cmd_t          dp_cmd;
  pfla_sts_t          dp_sts;
  logic               cfg_we;
  logic [COUNT_W-1:0] pages_in_use;

  // register write lands in the access phase; only the aligned address decodes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr == REG_ADDR_PAGES_IN_USE);
  assign prdata = (paddr == REG_ADDR_PAGES_IN_USE) ? 32'(pages_in_use) : '0;

  // sequencer: owns the handshake on the command channel
  pfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // stack, batch buffer, bitmap and the output register
  pfla_dpath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .in_data_i      (in_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[COUNT_W-1:0]),
    .pages_in_use_o (pages_in_use)
  );

endmodule

`default_nettype wire

### src/pfla_checker.sv
`default_nettype none

module pfla_checker import pfla_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input pfla_req_t   in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input pfla_rsp_t   out_data_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a nonzero allocate always leaves the block busy in the cycle after it is accepted
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.cmd == CMD_ALLOC) && (in_data_i.alloc_count != '0)
    |=> !in_ready_o)
    else $error("ready after a nonzero allocate");

  // an id in the middle of a batch is only buffered
  a_batch_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.cmd == CMD_FREE) && !in_data_i.batch_last
    |=> in_ready_o)
    else $error("busy after a buffered free id");

  // an in-range page count reads back as written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr == REG_ADDR_PAGES_IN_USE)
    && (pwdata[COUNT_W-1:0] <= COUNT_W'(POOL_PAGES))
    |=> (paddr != REG_ADDR_PAGES_IN_USE)
        || (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])))
    else $error("page count readback mismatch");

endmodule

bind page_free_list_allocator_core pfla_checker #(
  .POOL_PAGES (POOL_PAGES)
) u_pfla_checker (.*);

`default_nettype wire

### dv/pfla_pool_checker.sv
`default_nettype none

// watches both channels and the register port, predicts every result of the
// page pool and compares accepted results against the oldest outstanding one
module pfla_pool_checker import pfla_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pfla_req_t         in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pfla_rsp_t         out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [1:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              pready_i,
  output int unsigned       fail_count_o,
  output int unsigned       owed_count_o
);

  // predicted pool
  int unsigned       pool_size;
  logic [PAGE_W-1:0] spare_pages [POOL_PAGES];
  int unsigned       spare_top;
  logic              page_idle [POOL_PAGES];
  logic [PAGE_W-1:0] batch_ids [POOL_PAGES];
  int unsigned       batch_cnt;
  logic              batch_spilled;

  pfla_rsp_t   owed_rsp_q [$];
  int unsigned mismatches;

  task automatic pool_restart(input int unsigned size);
    pool_size = (size > POOL_PAGES) ? POOL_PAGES : size;
    for (int unsigned i = 0; i < POOL_PAGES; i++) begin
      spare_pages[i] = (i < pool_size) ? PAGE_W'(pool_size - 1 - i) : '0;
      page_idle[i]   = (i < pool_size);
      batch_ids[i]   = '0;
    end
    spare_top     = pool_size;
    batch_cnt     = 0;
    batch_spilled = 1'b0;
  endtask

  function automatic pfla_rsp_t pool_rsp(input logic [STATUS_W-1:0] st,
                                         input logic [PAGE_W-1:0] pg,
                                         input logic vld, input logic lst);
    pfla_rsp_t r;
    r.status          = st;
    r.page_out        = pg;
    r.page_valid      = vld;
    r.last_result     = lst;
    r.free_pages_left = COUNT_W'(spare_top);
    return r;
  endfunction

  task automatic take_pages(input int unsigned n);
    logic [PAGE_W-1:0] pg;
    if (n > spare_top) begin
      owed_rsp_q.push_back(pool_rsp(STATUS_NO_SPACE, '0, 1'b0, 1'b1));
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      spare_top--;
      pg = spare_pages[spare_top];
      page_idle[pg] = 1'b0;
      owed_rsp_q.push_back(pool_rsp(STATUS_OK, pg, 1'b1, i == n - 1));
    end
  endtask

  // first offending id in arrival order decides the status
  function automatic logic [STATUS_W-1:0] batch_verdict();
    if (batch_spilled) return STATUS_BAD_ID;
    for (int unsigned i = 0; i < batch_cnt; i++) begin
      if (batch_ids[i] >= pool_size) return STATUS_BAD_ID;
      if (page_idle[batch_ids[i]]) return STATUS_DOUBLE_FREE;
    end
    // repeated ids inside a batch can push the stack past its size
    if (spare_top + batch_cnt > POOL_PAGES) return STATUS_BAD_ID;
    return STATUS_OK;
  endfunction

  task automatic return_page(input logic [PAGE_W-1:0] pg, input logic lst);
    logic [STATUS_W-1:0] verdict;
    if (batch_cnt < POOL_PAGES) begin
      batch_ids[batch_cnt] = pg;
      batch_cnt++;
    end else begin
      batch_spilled = 1'b1;
    end
    if (!lst) return;
    verdict = batch_verdict();
    if (verdict == STATUS_OK) begin
      for (int unsigned i = 0; i < batch_cnt; i++) begin
        spare_pages[spare_top] = batch_ids[i];
        spare_top++;
        page_idle[batch_ids[i]] = 1'b1;
      end
    end
    batch_cnt     = 0;
    batch_spilled = 1'b0;
    owed_rsp_q.push_back(pool_rsp(verdict, '0, 1'b0, 1'b1));
  endtask

  task automatic match_result(input pfla_rsp_t got);
    pfla_rsp_t want;
    if (owed_rsp_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result st=%0d pg=%0d v=%0b l=%0b left=%0d",
                 got.status, got.page_out, got.page_valid, got.last_result,
                 got.free_pages_left);
      mismatches++;
      return;
    end
    want = owed_rsp_q.pop_front();
    if (got.status != want.status || got.page_out != want.page_out ||
        got.page_valid != want.page_valid || got.last_result != want.last_result ||
        got.free_pages_left != want.free_pages_left) begin
      if (mismatches < 10)
        $display({"result differs: exp st=%0d pg=%0d v=%0b l=%0b left=%0d, ",
                  "got st=%0d pg=%0d v=%0b l=%0b left=%0d"},
                 want.status, want.page_out, want.page_valid, want.last_result,
                 want.free_pages_left, got.status, got.page_out, got.page_valid,
                 got.last_result, got.free_pages_left);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_restart(POOL_PAGES);
      owed_rsp_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      owed_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == REG_ADDR_PAGES_IN_USE)
        pool_restart(int'(pwdata_i[COUNT_W-1:0]));
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.cmd == CMD_ALLOC) take_pages(int'(in_data_i.alloc_count));
        else return_page(in_data_i.page_id, in_data_i.batch_last);
      end
      if (out_valid_i && out_ready_i) match_result(out_data_i);
      fail_count_o <= mismatches;
      owed_count_o <= owed_rsp_q.size();
    end
  end

endmodule

`default_nettype wire

### dv/tb_page_free_list_allocator_core.sv
`default_nettype none

// top: makes allocate and free traffic, programs the pool size and gives the
// verdict; prediction and comparison live in the pool checker
module tb_page_free_list_allocator_core;
  import pfla_pkg::*;

  localparam int unsigned POOL_PAGES  = 64;
  localparam int unsigned PHASE_ITEMS = 14;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  pfla_req_t   in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pfla_rsp_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [1:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned owed;

  // sender and receiver shaping, changed per phase
  int unsigned gap_max    = 0;
  int unsigned stall_pct  = 0;
  int unsigned burst_left = 0;
  int unsigned stall_hold = 0;
  int unsigned items_sent = 0;

  // pages handed out by the block and not yet given back by the stimulus
  logic [PAGE_W-1:0] held_pages [$];

  page_free_list_allocator_core #(
    .POOL_PAGES (POOL_PAGES)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pfla_pool_checker #(
    .POOL_PAGES (POOL_PAGES)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .owed_count_o (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit: far beyond the slowest legal run, even with every
  // allocation at 64 pages and long receiver stalls
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls at the phase rate, now and then a long hold
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      out_ready  <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      if ($urandom_range(15) == 0) stall_hold <= $urandom_range(1, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // remember every page the block hands out so batches can give it back
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.page_valid)
      held_pages.push_back(out_data.page_out);
  end

  // allocate request, unused fields random
  function automatic pfla_req_t alloc_req(input int unsigned n);
    pfla_req_t r;
    r.cmd         = CMD_ALLOC;
    r.alloc_count = COUNT_W'(n);
    r.page_id     = PAGE_W'($urandom);
    r.batch_last  = 1'($urandom);
    return r;
  endfunction

  // one id of a free batch, unused count random
  function automatic pfla_req_t free_req(input logic [PAGE_W-1:0] pg, input logic lst);
    pfla_req_t r;
    r.cmd         = CMD_FREE;
    r.alloc_count = COUNT_W'($urandom_range(POOL_PAGES));
    r.page_id     = pg;
    r.batch_last  = lst;
    return r;
  endfunction

  // one transaction on the command channel; valid is left high on return,
  // so anything that lets time pass drops it first
  task automatic push_item(input pfla_req_t req);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold the sender until every predicted result has come back, then give
  // resultless items (mid-batch ids, empty allocations) time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (12) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_pool_size(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_PAGES_IN_USE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the pool restarts full, nothing is held any more
    held_pages.delete();
  endtask

  // well-formed batch of pages the block really handed out,
  // sometimes with an allocation slipped in mid-batch
  task automatic give_back_held();
    int unsigned n;
    int unsigned idx;
    logic [PAGE_W-1:0] pg;
    n = $urandom_range(1, (held_pages.size() < 6) ? held_pages.size() : 6);
    for (int unsigned i = 0; i < n; i++) begin
      idx = $urandom_range(held_pages.size() - 1);
      pg  = held_pages[idx];
      held_pages.delete(idx);
      push_item(free_req(pg, i == n - 1));
      if (i != n - 1 && $urandom_range(9) == 0)
        push_item(alloc_req($urandom_range(1, 3)));
    end
  endtask

  // noise batch: arbitrary ids, so double frees and out-of-range ids,
  // with an occasional repeated id
  task automatic noisy_batch();
    int unsigned n;
    logic [PAGE_W-1:0] pg;
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(4) != 0) pg = PAGE_W'($urandom_range(POOL_PAGES - 1));
      push_item(free_req(pg, i == n - 1));
    end
  endtask

  // mostly small requests, some empty, a few up to the whole pool
  function automatic int unsigned alloc_size();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(POOL_PAGES);
    return $urandom_range(1, 6);
  endfunction

  task automatic random_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) push_item(alloc_req(alloc_size()));
      else if (pick < 75 && held_pages.size() != 0) give_back_held();
      else if (pick < 96) noisy_batch();
      else wait_idle();
    end
  endtask

  initial begin
    int unsigned pool_sizes [7];
    int unsigned gaps [7];
    int unsigned stalls [7];
    pool_sizes = '{64, 1, 0, 100, 127, 17, 0};
    gaps       = '{0, 4, 20, 2, 0, 8, 1};
    stalls     = '{0, 40, 10, 60, 0, 25, 15};
    pool_sizes[6] = $urandom_range(2, POOL_PAGES - 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the full reset pool
    gap_max   = 3;
    stall_pct = 30;
    push_item(alloc_req(0));                  // empty allocation, no result
    push_item(alloc_req(3));                  // pages 0, 1, 2
    push_item(alloc_req(POOL_PAGES));         // more than is free
    push_item(free_req(6'd2, 1'b0));
    push_item(alloc_req(1));                  // allocation inside a batch
    push_item(free_req(6'd1, 1'b1));          // clean commit
    push_item(free_req(6'd1, 1'b1));          // double free
    push_item(free_req(6'd0, 1'b0));
    push_item(free_req(6'd0, 1'b1));          // repeated id fills the stack
    push_item(free_req(6'd3, 1'b1));          // stack would overflow
    push_item(alloc_req(POOL_PAGES));         // whole pool at once
    push_item(alloc_req(1));                  // pool empty
    wait_idle();

    // small pool: range checks and scan order
    write_pool_size(32'd5);
    push_item(free_req(6'd63, 1'b1));         // id out of range
    push_item(alloc_req(5));
    push_item(free_req(6'd4, 1'b0));
    push_item(free_req(6'd9, 1'b1));          // valid id then bad id
    push_item(free_req(6'd4, 1'b1));
    push_item(free_req(6'd4, 1'b0));
    push_item(free_req(6'd60, 1'b1));         // double free ahead of bad id
    // batch longer than its buffer
    for (int unsigned k = 0; k <= POOL_PAGES; k++)
      push_item(free_req(PAGE_W'($urandom_range(POOL_PAGES - 1)), k == POOL_PAGES));

    // random phases over several pool sizes, saturating and empty ones too
    for (int unsigned p = 0; p < 7; p++) begin
      wait_idle();
      write_pool_size(pool_sizes[p]);
      gap_max   = gaps[p];
      stall_pct = stalls[p];
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (fail_count == 0 && owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/pfla_pkg.sv
src/pfla_ctrl.sv
src/pfla_dpath.sv
src/page_free_list_allocator_core.sv
src/pfla_checker.sv
dv/pfla_pool_checker.sv
dv/tb_page_free_list_allocator_core.sv
